// ===== hw/rtl/hcmd_pkg.sv =====
// Package for the HUI control message decoder.
// Word types, message kinds, event codes and controller constants.
// No dependencies.
`default_nettype none

package hcmd_pkg;

   // message kinds on the request word
   localparam logic [1:0] MODE_NOTE_ON   = 2'd0;
   localparam logic [1:0] MODE_POLY_PRES = 2'd1;
   localparam logic [1:0] MODE_CTRL_CHG  = 2'd2;

   // controller groups (upper three bits of the controller number)
   localparam logic [2:0] GRP_FADER_MSB = 3'h0;
   localparam logic [2:0] GRP_VPOT      = 3'h1;
   localparam logic [2:0] GRP_FADER_LSB = 3'h2;

   localparam logic [6:0] CC_ZONE_SELECT = 7'h0C;
   localparam logic [6:0] CC_PORT_SWITCH = 7'h2C;

   typedef enum logic [2:0] {
      EV_VU        = 3'd0,
      EV_FADER     = 3'd1,
      EV_VPOT      = 3'd2,
      EV_LED       = 3'd3,
      EV_BAD_NOTE  = 3'd4,
      EV_UNP_MSB   = 3'd5,
      EV_UNP_LSB   = 3'd6,
      EV_UNHANDLED = 3'd7
   } event_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [6:0] number;
      logic [6:0] value;
   } req_word_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [6:0] index;
      logic       flag;
      logic [6:0] zone;
      logic [9:0] level;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hcmd_decode.sv =====
// Message decode logic and the decoder's persistent state
// (LED zone, fader halves and pairing marks). Uses hcmd_pkg.
`default_nettype none

module hcmd_decode (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire hcmd_pkg::req_word_type word,
   output logic                      has_result,
   output hcmd_pkg::rsp_word_type    result
);
   import hcmd_pkg::*;

   logic [6:0] led_zone_ff, led_zone_in;
   logic [3:0] fader_number_ff, fader_number_in;
   logic [6:0] high_part_ff, high_part_in;
   logic [6:0] low_part_ff, low_part_in;
   logic       high_waiting_ff, high_waiting_in;
   logic       low_waiting_ff, low_waiting_in;

   logic [9:0] position;

   // position from the halves as they stand after this message
   assign position = {high_part_in, 3'b000} + {7'd0, low_part_in[6:4]};

   always_comb begin
      led_zone_in     = led_zone_ff;
      fader_number_in = fader_number_ff;
      high_part_in    = high_part_ff;
      low_part_in     = low_part_ff;
      high_waiting_in = high_waiting_ff;
      low_waiting_in  = low_waiting_ff;
      has_result      = 1'b0;
      result          = '0;
      result.index    = word.number;
      result.level    = {3'd0, word.value};

      unique case (word.mode)
         MODE_NOTE_ON: begin
            // all-zero note is the ping
            has_result       = (word.number != 7'd0) || (word.value != 7'd0);
            result.event_res = EV_BAD_NOTE;
         end
         MODE_POLY_PRES: begin
            has_result       = 1'b1;
            result.event_res = EV_VU;
            result.flag      = word.value[4];
            result.level     = {6'd0, word.value[3:0]};
         end
         MODE_CTRL_CHG: begin
            unique case (word.number[6:4])
               GRP_FADER_MSB: begin
                  if (word.number == CC_ZONE_SELECT) begin
                     led_zone_in = word.value;
                  end else begin
                     high_part_in    = word.value;
                     fader_number_in = word.number[3:0];
                     if (high_waiting_ff) begin
                        low_waiting_in   = 1'b0;
                        has_result       = 1'b1;
                        result.event_res = EV_UNP_MSB;
                        result.index     = {3'd0, fader_number_ff};
                     end else if (low_waiting_ff) begin
                        low_waiting_in   = 1'b0;
                        has_result       = 1'b1;
                        result.event_res = EV_FADER;
                        result.index     = {3'd0, word.number[3:0]};
                        result.level     = position;
                     end else begin
                        high_waiting_in = 1'b1;
                     end
                  end
               end
               GRP_VPOT: begin
                  has_result       = 1'b1;
                  result.event_res = EV_VPOT;
                  result.index     = {3'd0, word.number[3:0]};
               end
               GRP_FADER_LSB: begin
                  if (word.number == CC_PORT_SWITCH) begin
                     has_result       = 1'b1;
                     result.event_res = EV_LED;
                     result.index     = {3'd0, word.value[3:0]};
                     result.flag      = word.value[6];
                     result.zone      = led_zone_ff;
                     result.level     = '0;
                  end else begin
                     low_part_in     = word.value;
                     fader_number_in = word.number[3:0];
                     if (low_waiting_ff) begin
                        high_waiting_in  = 1'b0;
                        has_result       = 1'b1;
                        result.event_res = EV_UNP_LSB;
                        result.index     = {3'd0, fader_number_ff};
                     end else if (high_waiting_ff) begin
                        high_waiting_in  = 1'b0;
                        has_result       = 1'b1;
                        result.event_res = EV_FADER;
                        result.index     = {3'd0, word.number[3:0]};
                        result.level     = position;
                     end else begin
                        low_waiting_in = 1'b1;
                     end
                  end
               end
               default: begin
                  has_result       = 1'b1;
                  result.event_res = EV_UNHANDLED;
               end
            endcase
         end
         default: begin
            // unused kind: dropped, state untouched
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_zone_ff     <= '0;
         fader_number_ff <= '0;
         high_part_ff    <= '0;
         low_part_ff     <= '0;
         high_waiting_ff <= 1'b0;
         low_waiting_ff  <= 1'b0;
      end else if (fire) begin
         led_zone_ff     <= led_zone_in;
         fader_number_ff <= fader_number_in;
         high_part_ff    <= high_part_in;
         low_part_ff     <= low_part_in;
         high_waiting_ff <= high_waiting_in;
         low_waiting_ff  <= low_waiting_in;
      end
   end

`ifndef ASSERT_OFF
   // at most one fader half is ever left waiting
   a_one_half_waits: assert property (@(posedge clock) disable iff (reset)
      !(high_waiting_ff && low_waiting_ff))
      else $error("both fader halves marked waiting");

   // a paired position always clears both marks
   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && (result.event_res == EV_FADER)
      |=> !high_waiting_ff && !low_waiting_ff)
      else $error("fader pair left a half waiting");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hui_control_message_decoder.sv =====
// HUI control message decoder: top level with input and result registers.
// Depends on hcmd_pkg and hcmd_decode.
//
// Usage:
//   req channel carries one MIDI channel-voice message per word (mode,
//   number, value). A word is taken at a rising edge with req_valid high
//   and req_stall low.
//   rsp channel carries one decoded event per word (event_res, index, flag,
//   zone, level), taken at a rising edge with rsp_valid high and rsp_stall
//   low. Messages that decode to nothing (ping, zone select, the first
//   fader half, unused kind) produce no rsp word.
//   Path: an accepted word passes the input register, the decode logic and
//   the result register before its result is on rsp; rsp_stall can hold it
//   in either register.
//   Throughput: one word per cycle while no result word is stalled on rsp,
//   set by the single decode pass between the input and result registers.
//   Stall: while the result register holds a word that is stalled, the
//   input register keeps its word and req_stall rises once the input
//   register is full; a word that yields no result still waits for the
//   result stage to be free so that state updates stay in order.
//   Reset (synchronous, active high) empties both registers and clears the
//   LED zone, fader number, fader halves and pairing marks.
`default_nettype none

module hui_control_message_decoder (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire hcmd_pkg::req_word_type req_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output hcmd_pkg::rsp_word_type    rsp_word
);
   import hcmd_pkg::*;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;

   // result register
   logic         s2_valid_ff, s2_valid_in;
   rsp_word_type s2_word_ff;

   logic         s1_adv;      // input word is decoded this cycle
   logic         req_accept;
   logic         rsp_accept;
   logic         dec_has_result;
   rsp_word_type dec_result;

   assign rsp_accept = s2_valid_ff && !rsp_stall;
   // result stage is free, or frees up this cycle
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   hcmd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (s1_adv),
      .word       (s1_word_ff),
      .has_result (dec_has_result),
      .result     (dec_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_adv && dec_has_result) begin
         s2_valid_in = 1'b1;
      end else if (rsp_accept) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff <= req_word;
      end
      if (s1_adv && dec_has_result) begin
         s2_word_ff <= dec_result;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_word  = s2_word_ff;

`ifndef ASSERT_OFF
   // the input side only stalls when a word is parked in the input register
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("req_stall without a blocked input word");

   // a stalled result is never overwritten by a new decode
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && rsp_stall |-> !s1_adv)
      else $error("decode advanced into a stalled result register");

   // a result taken with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && !s1_valid_ff |=> !rsp_valid)
      else $error("result repeated after it was taken");
`endif

endmodule

`default_nettype wire
